// ===== hw/rtl/bfe_pkg.sv =====
package bfe_pkg;

	localparam int HASH_W    = 32;
	localparam int FB_W      = 13;
	localparam int HC_W      = 6;
	localparam int ROT       = 17;
	localparam int MOD_STEP  = 4;
	localparam int MOD_CYCLES = HASH_W / MOD_STEP;
	localparam int MOD_CNT_W = $clog2(MOD_CYCLES);

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_QUERY  = 1'b1;

	localparam logic REG_FILTER_BYTES = 1'b0;
	localparam logic REG_HASH_COUNT   = 1'b1;

	localparam logic [FB_W-1:0] FB_RESET = 13'd4096;
	localparam logic [HC_W-1:0] HC_RESET = 6'd4;

	typedef struct packed {
		logic load;
		logic mod_start;
		logic mem_rd;
		logic mem_wr;
		logic clr_wr;
		logic hash_adv;
		logic res_load;
		logic res_found;
	} cmd_t;

	typedef struct packed {
		logic mod_busy;
		logic bit_set;
		logic clr_last;
		logic func;
	} status_t;

endpackage

// ===== hw/rtl/bfe_modunit.sv =====
module bfe_modunit #(
	parameter int BW = 13
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bfe_pkg::HASH_W-1:0] dividend,
	input  logic [BW-1:0]              divisor,
	output logic                       busy,
	output logic [BW-1:0]              remainder
);
	import bfe_pkg::*;

	logic                 busy_q;
	logic [MOD_CNT_W-1:0] cnt_q;
	logic [HASH_W-1:0]    dvd_q;
	logic [BW-1:0]        div_q;
	logic [BW-1:0]        rem_q;
	logic [BW:0]          t_c;
	logic [BW-1:0]        r_c;

	// restoring division, MOD_STEP quotient bits per cycle
	always_comb begin
		r_c = rem_q;
		t_c = '0;
		for (int i = 0; i < MOD_STEP; i++) begin
			t_c = {r_c, dvd_q[HASH_W-1-i]};
			if (t_c >= {1'b0, div_q}) begin
				t_c = t_c - {1'b0, div_q};
			end
			r_c = t_c[BW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == MOD_CNT_W'(MOD_CYCLES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << MOD_STEP;
			rem_q <= r_c;
		end
	end

	assign busy      = busy_q;
	assign remainder = rem_q;

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rem_q < div_q))
		else $error("partial remainder not below divisor");

endmodule

// ===== hw/rtl/bfe_datapath.sv =====
module bfe_datapath #(
	parameter int MAX_BYTES = 4096
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  bfe_pkg::cmd_t                               cmd,
	input  logic                                        func,
	input  logic [bfe_pkg::HASH_W-1:0]                  key_hash,
	input  logic [$clog2(MAX_BYTES+1)-1:0]              eff_bytes,
	output bfe_pkg::status_t                            status,
	output logic                                        may_exist
);
	import bfe_pkg::*;

	localparam int BW = $clog2(MAX_BYTES + 1);
	localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

	logic [7:0]        mem [MAX_BYTES];
	logic [7:0]        rd_q;
	logic [HASH_W-1:0] hash_q;
	logic              func_q;
	logic              may_exist_q;
	logic [AW-1:0]     clr_addr_q;

	logic [HASH_W-1:0] hash_nxt;
	logic [HASH_W-1:0] dvd_src;
	logic [HASH_W-1:0] dividend;
	logic [BW-1:0]     rem;
	logic              mod_busy;
	logic [AW-1:0]     addr;
	logic [7:0]        mask;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [7:0]        wdata;

	// next probe: h + rotr(h, 17)
	assign hash_nxt = hash_q + {hash_q[ROT-1:0], hash_q[HASH_W-1:ROT]};
	assign dvd_src  = cmd.load ? key_hash : hash_nxt;
	// bit position mod 8*bytes splits into byte (hash/8 mod bytes) and low three bits
	assign dividend = {3'b000, dvd_src[HASH_W-1:3]};

	bfe_modunit #(.BW(BW)) u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mod_start),
		.dividend  (dividend),
		.divisor   (eff_bytes),
		.busy      (mod_busy),
		.remainder (rem)
	);

	assign addr  = rem[AW-1:0];
	assign mask  = 8'd1 << hash_q[2:0];
	assign we    = cmd.mem_wr | cmd.clr_wr;
	assign waddr = cmd.clr_wr ? clr_addr_q : addr;
	assign wdata = cmd.clr_wr ? 8'd0 : (rd_q | mask);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (cmd.mem_rd) begin
			rd_q <= mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hash_q <= key_hash;
			func_q <= func;
		end else if (cmd.hash_adv) begin
			hash_q <= hash_nxt;
		end
		if (cmd.res_load) begin
			may_exist_q <= (func_q == FUNC_QUERY) & cmd.res_found;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_wr) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	assign status.mod_busy = mod_busy;
	assign status.bit_set  = |(rd_q & mask);
	assign status.clr_last = (clr_addr_q == AW'(MAX_BYTES - 1));
	assign status.func     = func_q;
	assign may_exist       = may_exist_q;

endmodule

// ===== hw/rtl/bfe_ctrl.sv =====
module bfe_ctrl #(
	parameter int MAX_HASHES = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	output logic                                result_valid,
	input  logic                                result_ready,
	input  logic [$clog2(MAX_HASHES+1)-1:0]     eff_hashes,
	input  bfe_pkg::status_t                    status,
	output bfe_pkg::cmd_t                       cmd
);
	import bfe_pkg::*;

	localparam int HW = $clog2(MAX_HASHES + 1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MOD   = 3'd2;
	localparam logic [2:0] ST_CHK   = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0]    state_q, state_d;
	logic [HW-1:0] cnt_q, cnt_d;
	logic          found_q, found_d;
	logic          result_valid_q;
	logic [HW-1:0] cnt_inc;

	assign cnt_inc    = cnt_q + 1'b1;
	assign item_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		found_d = found_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (item_valid) begin
					cmd.load = 1'b1;
					cnt_d    = '0;
					found_d  = 1'b1;
					if (eff_hashes == '0) begin
						state_d = ST_DONE;
					end else begin
						cmd.mod_start = 1'b1;
						state_d       = ST_MOD;
					end
				end
			end
			ST_MOD: begin
				if (!status.mod_busy) begin
					cmd.mem_rd = 1'b1;
					state_d    = ST_CHK;
				end
			end
			ST_CHK: begin
				if (status.func == FUNC_INSERT) begin
					cmd.mem_wr = 1'b1;
				end
				if ((status.func == FUNC_QUERY) && !status.bit_set) begin
					found_d = 1'b0;
					state_d = ST_DONE;
				end else if (cnt_inc == eff_hashes) begin
					state_d = ST_DONE;
				end else begin
					cmd.hash_adv  = 1'b1;
					cmd.mod_start = 1'b1;
					cnt_d         = cnt_inc;
					state_d       = ST_MOD;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || result_ready) begin
					cmd.res_load  = 1'b1;
					cmd.res_found = found_q;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			cnt_q          <= '0;
			found_q        <= 1'b1;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			found_q <= found_d;
			if (cmd.res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOD) |-> (cnt_q < eff_hashes))
		else $error("probe index past probe count");

	a_mod_starts: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mod_start |=> status.mod_busy)
		else $error("modulo unit did not start");

	a_write_on_insert: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr |-> (status.func == FUNC_INSERT))
		else $error("store written during a query");

	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> !result_valid_q)
		else $error("result raised during clearing pass");

endmodule

// ===== hw/rtl/bloom_filter_engine_top.sv =====
// Bloom filter engine over an internal byte-wide bit store.
// Item channel (item_valid/item_ready, func, key_hash): func 0 inserts the key,
// func 1 queries it. key_hash is the key's 32-bit hash, computed upstream.
// Result channel (result_valid/result_ready, may_exist): one result per item;
// may_exist is 1 for a query whose probed bits are all set, 0 otherwise.
// Registers on the APB port: 0x0 filter_bytes, 0x4 hash_count. Write them only
// while no transaction is in flight.
// Each probe computes the byte index modulo (4 bits a cycle), then does one
// store read and one check/write. The next item can be taken once the result
// is loaded; a query ends at its first clear bit.
// One item is worked on at a time. The next item is accepted while a result
// still waits in the output register; a stalled receiver holds the engine
// only when the next result is ready to be written.
// After reset the store is swept to zero, one byte a cycle, over all MAX_BYTES
// bytes; item_ready stays low until the sweep ends.
module bloom_filter_engine_top #(
	parameter int MAX_BYTES  = 4096,
	parameter int MAX_HASHES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_ready,
	input  logic        func,
	input  logic [31:0] key_hash,
	output logic        result_valid,
	input  logic        result_ready,
	output logic        may_exist
);
	import bfe_pkg::*;

	localparam int BW = $clog2(MAX_BYTES + 1);
	localparam int HW = $clog2(MAX_HASHES + 1);

	logic [FB_W-1:0] filter_bytes_q;
	logic [HC_W-1:0] hash_count_q;
	logic            wr_en;
	logic [31:0]     fb_ext;
	logic [31:0]     hc_ext;
	logic [BW-1:0]   eff_bytes;
	logic [HW-1:0]   eff_hashes;
	cmd_t            cmd;
	status_t         status;

	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_bytes_q <= FB_RESET;
			hash_count_q   <= HC_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_FILTER_BYTES: filter_bytes_q <= pwdata[FB_W-1:0];
				REG_HASH_COUNT:   hash_count_q   <= pwdata[HC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_FILTER_BYTES: prdata = 32'(filter_bytes_q);
			REG_HASH_COUNT:   prdata = 32'(hash_count_q);
			default:          prdata = '0;
		endcase
	end

	// zero size counts as one byte, oversize saturates
	assign fb_ext = 32'(filter_bytes_q);
	assign hc_ext = 32'(hash_count_q);
	assign eff_bytes = (fb_ext == 32'd0) ? BW'(1) :
		(fb_ext > 32'(MAX_BYTES)) ? BW'(MAX_BYTES) : BW'(fb_ext);
	assign eff_hashes = (hc_ext > 32'(MAX_HASHES)) ? HW'(MAX_HASHES) : HW'(hc_ext);

	bfe_ctrl #(.MAX_HASHES(MAX_HASHES)) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.eff_hashes   (eff_hashes),
		.status       (status),
		.cmd          (cmd)
	);

	bfe_datapath #(.MAX_BYTES(MAX_BYTES)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.func      (func),
		.key_hash  (key_hash),
		.eff_bytes (eff_bytes),
		.status    (status),
		.may_exist (may_exist)
	);

endmodule
